### rtl/nearest_target_selector_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest target selector
// Implication checks on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TARGET_SELECTOR_UNIT_DEFINES_SVH
`define NEAREST_TARGET_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define NTS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nearest target selector: same-cycle check failed");

// next-cycle implication
`define NTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nearest target selector: next-cycle check failed");

`endif

### rtl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types, codes and the coordinate scaling for the target selector.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int SLOT_W  = 5;
    localparam int RAW_W   = 8;
    localparam int PT_W    = 16;
    localparam int POS_W   = 24;
    localparam int OFF_W   = 25;
    localparam int Q8_W    = 17;
    localparam int PROD_W  = 25;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DIST_W  = SQ_W + 1;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_PLAN   = 1'b1;
    localparam logic [16:0] SCALE_MUL = 17'd66322;

    typedef struct packed {
        logic             pending;
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } nts_entry_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } nts_cell_ctrl_t;

    typedef struct packed {
        logic busy;
        logic have;
    } nts_stat_t;

    function automatic logic [Q8_W-1:0] to_q8(input logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(SCALE_MUL);
        return prod[PROD_W-1:8];
    endfunction

endpackage

### rtl/nts_cell.sv
// ----------------------------------------------------------------------------
// nts_cell
// One target slot of the ring: pending flag and raw coordinates, shifted on
// toward the head during a scan.
// ----------------------------------------------------------------------------
module nts_cell
    import nts_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  nts_cell_ctrl_t ctrl,
    input  logic [PT_W-1:0] load_point,
    input  nts_entry_t     from_next,
    output nts_entry_t     entry
);

    logic             pending_reg;
    logic [RAW_W-1:0] x_reg;
    logic [RAW_W-1:0] y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else if (ctrl.load) begin
            pending_reg <= 1'b1;
        end else if (ctrl.clear) begin
            pending_reg <= 1'b0;
        end else if (ctrl.shift) begin
            pending_reg <= from_next.pending;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            x_reg <= load_point[PT_W-1:RAW_W];
            y_reg <= load_point[RAW_W-1:0];
        end else if (ctrl.shift) begin
            x_reg <= from_next.x;
            y_reg <= from_next.y;
        end
    end

    assign entry = {pending_reg, x_reg, y_reg};

endmodule

### rtl/nts_dist.sv
// ----------------------------------------------------------------------------
// nts_dist
// Distance pipeline at the ring head: offset, square, then compare against
// the nearest candidate so far.
// ----------------------------------------------------------------------------
module nts_dist
    import nts_pkg::*;
#(
    parameter int IW = 5
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic                    in_valid,
    input  logic [IW-1:0]           in_idx,
    input  nts_entry_t              in_entry,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    output nts_stat_t               stat,
    output logic [IW-1:0]           best_idx,
    output logic [OFF_W-1:0]        best_dx,
    output logic [OFF_W-1:0]        best_dy
);

    logic              p1_valid_reg;
    logic [IW-1:0]     p1_idx_reg;
    logic [OFF_W-1:0]  p1_dx_reg;
    logic [OFF_W-1:0]  p1_dy_reg;

    logic              p2_valid_reg;
    logic [IW-1:0]     p2_idx_reg;
    logic [OFF_W-1:0]  p2_dx_reg;
    logic [OFF_W-1:0]  p2_dy_reg;
    logic [SQ_W-1:0]   p2_sqx_reg;
    logic [SQ_W-1:0]   p2_sqy_reg;

    logic              have_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [OFF_W-1:0]  best_dx_reg;
    logic [OFF_W-1:0]  best_dy_reg;
    logic [DIST_W-1:0] best_d_reg;

    logic signed [OFF_W:0] diff_x;
    logic signed [OFF_W:0] diff_y;
    logic [OFF_W-1:0]      abs_x;
    logic [OFF_W-1:0]      abs_y;
    logic [MAG_W-1:0]      mag_x;
    logic [MAG_W-1:0]      mag_y;
    logic [DIST_W-1:0]     dist_sum;
    logic                  better;

    always_comb begin
        diff_x = $signed({{(OFF_W+1-Q8_W){1'b0}}, to_q8(in_entry.x)})
               - $signed({{(OFF_W+1-POS_W){pos_x[POS_W-1]}}, pos_x});
        diff_y = $signed({{(OFF_W+1-Q8_W){1'b0}}, to_q8(in_entry.y)})
               - $signed({{(OFF_W+1-POS_W){pos_y[POS_W-1]}}, pos_y});
        abs_x    = p1_dx_reg[OFF_W-1] ? (~p1_dx_reg + 1'b1) : p1_dx_reg;
        abs_y    = p1_dy_reg[OFF_W-1] ? (~p1_dy_reg + 1'b1) : p1_dy_reg;
        mag_x    = abs_x[MAG_W-1:0];
        mag_y    = abs_y[MAG_W-1:0];
        dist_sum = DIST_W'(p2_sqx_reg) + DIST_W'(p2_sqy_reg);
        better   = !have_reg || (dist_sum < best_d_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
        end else begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
            if (start) begin
                have_reg <= 1'b0;
            end else if (p2_valid_reg && better) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg <= in_idx;
        p1_dx_reg  <= diff_x[OFF_W-1:0];
        p1_dy_reg  <= diff_y[OFF_W-1:0];
        p2_idx_reg <= p1_idx_reg;
        p2_dx_reg  <= p1_dx_reg;
        p2_dy_reg  <= p1_dy_reg;
        p2_sqx_reg <= mag_x * mag_x;
        p2_sqy_reg <= mag_y * mag_y;
        if (p2_valid_reg && better) begin
            best_idx_reg <= p2_idx_reg;
            best_dx_reg  <= p2_dx_reg;
            best_dy_reg  <= p2_dy_reg;
            best_d_reg   <= dist_sum;
        end
    end

    assign stat.busy = p1_valid_reg || p2_valid_reg;
    assign stat.have = have_reg;
    assign best_idx  = best_idx_reg;
    assign best_dx   = best_dx_reg;
    assign best_dy   = best_dy_reg;

endmodule

### rtl/nearest_target_selector_unit.sv
// ----------------------------------------------------------------------------
// nearest_target_selector_unit
// Target table with pending flags; a plan request picks the nearest pending
// target by squared distance and returns its slot and offsets.
// ----------------------------------------------------------------------------
// Input stream: s_tuser is the op (load or plan); s_tdata carries slot,
// packed point and the current position. A load gives no result. A plan
// rotates the slot ring past one distance pipeline at its head: a scan
// passes every slot through it in turn, a drain step waits until the
// pipeline is empty, and a finish step writes the result. A new item is
// taken once the previous plan has finished; loads follow each other
// every cycle. Ties go to the lowest slot.
// The result sits in an output register until taken; a plan that finishes
// while the earlier result is still stalled holds in its finish step, and
// the pending flag of the chosen slot is cleared only when the result is
// written. Reset clears all pending flags and the pipeline; coordinates are
// not cleared. Result: m_tuser = found, m_tdata = slot and offsets, all
// zero when nothing is pending.
// ----------------------------------------------------------------------------
`include "nearest_target_selector_unit_defines.svh"

module nearest_target_selector_unit
    import nts_pkg::*;
#(
    parameter int POINTS = 32
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // slot[4:0], packed_point[20:5], pos_x[44:21], pos_y[68:45]
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // target_slot[4:0], offset_x[29:5], offset_y[54:30]
    output logic [0:0]  m_tuser    // found[0]
);

    localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] scan_cnt_reg;

    logic signed [POS_W-1:0] pos_x_reg;
    logic signed [POS_W-1:0] pos_y_reg;

    logic              m_valid_reg;
    logic              m_found_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [OFF_W-1:0]  m_offx_reg;
    logic [OFF_W-1:0]  m_offy_reg;

    logic              in_xfer;
    logic              load_xfer;
    logic              plan_xfer;
    logic              out_free;
    logic              finish_go;
    logic [SLOT_W-1:0] in_slot;
    logic [PT_W-1:0]   in_point;

    nts_entry_t     ring [POINTS];
    nts_cell_ctrl_t ctrl [POINTS];

    nts_stat_t         stat;
    logic [IW-1:0]     best_idx;
    logic [OFF_W-1:0]  best_dx;
    logic [OFF_W-1:0]  best_dy;

    assign in_slot   = s_tdata[4:0];
    assign in_point  = s_tdata[20:5];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign load_xfer = in_xfer && (s_tuser[0] == OP_LOAD);
    assign plan_xfer = in_xfer && (s_tuser[0] == OP_PLAN);
    assign out_free  = !m_valid_reg || m_tready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    for (genvar i = 0; i < POINTS; i++) begin : g_cell
        assign ctrl[i].shift = (state_reg == ST_SCAN);
        assign ctrl[i].load  = load_xfer && (int'(in_slot) == i);
        assign ctrl[i].clear = finish_go && stat.have && (best_idx == IW'(i));

        nts_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[i]),
            .load_point (in_point),
            .from_next  (ring[(i + 1) % POINTS]),
            .entry      (ring[i])
        );
    end

    nts_dist #(
        .IW (IW)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (plan_xfer),
        .in_valid ((state_reg == ST_SCAN) && ring[0].pending),
        .in_idx   (scan_cnt_reg),
        .in_entry (ring[0]),
        .pos_x    (pos_x_reg),
        .pos_y    (pos_y_reg),
        .stat     (stat),
        .best_idx (best_idx),
        .best_dx  (best_dx),
        .best_dy  (best_dy)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (plan_xfer) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_cnt_reg == IW'(POINTS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end else begin
                scan_cnt_reg <= '0;
            end
            if (finish_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_xfer) begin
            pos_x_reg <= s_tdata[44:21];
            pos_y_reg <= s_tdata[68:45];
        end
        if (finish_go) begin
            m_found_reg <= stat.have;
            m_slot_reg  <= stat.have ? SLOT_W'(best_idx) : '0;
            m_offx_reg  <= stat.have ? best_dx : '0;
            m_offy_reg  <= stat.have ? best_dy : '0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_found_reg;
    assign m_tdata    = {1'b0, m_offy_reg, m_offx_reg, m_slot_reg};

    `NTS_ASSERT_NEXT(a_plan_starts_scan, aclk, aresetn, plan_xfer, state_reg == ST_SCAN)
    `NTS_ASSERT_NEXT(a_finish_holds_on_stall, aclk, aresetn,
        (state_reg == ST_FINISH) && m_valid_reg && !m_tready, state_reg == ST_FINISH)
    `NTS_ASSERT_IMPL(a_idle_pipe_empty, aclk, aresetn, state_reg == ST_IDLE, !stat.busy)
    `NTS_ASSERT_NEXT(a_result_after_finish, aclk, aresetn, finish_go, m_valid_reg)

endmodule

### sim/nearest_target_selector_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_target_selector_unit_test
// Streams load and plan requests into the target selector with random gaps
// on both sides. A local copy of the target table predicts every pick, and
// each result transfer is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module nearest_target_selector_unit_test;
    import nts_pkg::*;

    localparam int NUM_SLOTS = 32;
    localparam int RUN_ITEMS = 1200;
    localparam longint OFF_HI = (64'sd1 <<< 24) - 1;
    localparam longint OFF_LO = -(64'sd1 <<< 24);

    typedef struct {
        logic               op;
        logic [4:0]         slot;
        logic [15:0]        point;
        logic signed [23:0] px;
        logic signed [23:0] py;
    } cmd_t;

    typedef struct {
        logic        found;
        logic [4:0]  slot;
        logic [24:0] off_x;
        logic [24:0] off_y;
    } pick_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // slot[4:0], packed_point[20:5], pos_x[44:21], pos_y[68:45]
    logic [0:0]  s_tuser;   // op[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // target_slot[4:0], offset_x[29:5], offset_y[54:30]
    logic [0:0]  m_tuser;   // found[0]

    cmd_t        pending_cmds[$];
    pick_t       picks_due[$];
    logic [15:0] recent_pts[$];

    logic        armed[NUM_SLOTS];
    logic [7:0]  tgt_x[NUM_SLOTS];
    logic [7:0]  tgt_y[NUM_SLOTS];

    cmd_t  cur;
    pick_t got;
    pick_t want;
    logic  in_done;
    logic  out_done;
    int    tx_gap;
    int    rx_wait;
    int    tx_run;
    int    rx_run;
    int    err_cnt;
    int    n_queued;
    int    n_loads;
    int    n_plans;
    int    n_found;
    int    n_empty;
    int    n_ties;
    int    n_zero;

    nearest_target_selector_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int unsigned cm_q8(input logic [7:0] raw);
        return (32'(raw) * 32'd66322) >> 8;
    endfunction

    function automatic logic [24:0] clamp_offset(input longint v);
        if (v > OFF_HI) return 25'(OFF_HI);
        if (v < OFF_LO) return 25'(OFF_LO);
        return 25'(v);
    endfunction

    // quiet stretches with no idling break up the random pauses
    function automatic int next_pause(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 40) == 0) run = $urandom_range(20, 60);
        return $urandom_range(0, 11);
    endfunction

    task automatic take_item(input cmd_t c);
        pick_t  p;
        longint dx;
        longint dy;
        longint d;
        longint best_d;
        longint bx;
        longint by;
        int     best;
        int     i;
        bit     have;
        bit     tie;
        if (c.op == OP_LOAD) begin
            n_loads++;
            if (c.slot < NUM_SLOTS) begin
                tgt_y[c.slot] = c.point[7:0];
                tgt_x[c.slot] = c.point[15:8];
                armed[c.slot] = 1'b1;
            end
            return;
        end
        n_plans++;
        have = 0;
        tie = 0;
        best = 0;
        best_d = 0;
        bx = 0;
        by = 0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            if (armed[i]) begin
                dx = longint'(cm_q8(tgt_x[i])) - longint'(c.px);
                dy = longint'(cm_q8(tgt_y[i])) - longint'(c.py);
                d = dx * dx + dy * dy;
                if (!have || d < best_d) begin
                    have = 1;
                    tie = 0;
                    best = i;
                    best_d = d;
                    bx = dx;
                    by = dy;
                end else if (d == best_d) begin
                    tie = 1;
                end
            end
        end
        if (have) begin
            armed[best] = 1'b0;
            p.found = 1'b1;
            p.slot = 5'(best);
            p.off_x = clamp_offset(bx);
            p.off_y = clamp_offset(by);
            n_found++;
            if (tie) n_ties++;
            if (best_d == 0) n_zero++;
        end else begin
            p.found = 1'b0;
            p.slot = '0;
            p.off_x = '0;
            p.off_y = '0;
            n_empty++;
        end
        picks_due.push_back(p);
    endtask

    task automatic push_load(input logic [4:0] slot, input logic [15:0] pt);
        cmd_t c;
        c.op = OP_LOAD;
        c.slot = slot;
        c.point = pt;
        c.px = 24'($urandom);
        c.py = 24'($urandom);
        pending_cmds.push_back(c);
        recent_pts.push_back(pt);
        if (recent_pts.size() > 32) void'(recent_pts.pop_front());
        n_queued++;
    endtask

    task automatic push_plan(input logic signed [23:0] px, input logic signed [23:0] py);
        cmd_t c;
        c.op = OP_PLAN;
        c.slot = 5'($urandom);
        c.point = 16'($urandom);
        c.px = px;
        c.py = py;
        pending_cmds.push_back(c);
        n_queued++;
    endtask

    // aim at a loaded point, near the table's area, or anywhere in range
    task automatic random_plan();
        int          r;
        int          jx;
        int          jy;
        logic [15:0] pt;
        r = $urandom_range(0, 99);
        if (r < 22 && recent_pts.size() > 0) begin
            pt = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
            jx = (r < 12) ? 0 : int'($urandom_range(0, 6)) - 3;
            jy = (r < 12) ? 0 : int'($urandom_range(0, 6)) - 3;
            push_plan(24'(int'(cm_q8(pt[15:8])) + jx), 24'(int'(cm_q8(pt[7:0])) + jy));
        end else if (r < 78) begin
            push_plan(24'(int'($urandom_range(0, 70000)) - 2000),
                      24'(int'($urandom_range(0, 70000)) - 2000));
        end else begin
            push_plan(24'($urandom), 24'($urandom));
        end
    endtask

    task automatic random_load();
        if (recent_pts.size() > 0 && $urandom_range(0, 3) == 0)
            push_load(5'($urandom), recent_pts[$urandom_range(0, recent_pts.size() - 1)]);
        else
            push_load(5'($urandom), 16'($urandom));
    endtask

    always @(negedge aclk) begin : drive_in
        logic nv;
        nv = s_tvalid;
        if (aresetn) begin
            if (s_tvalid && in_done) nv = 1'b0;
            if (!nv) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_cmds.size() > 0) begin
                    cur = pending_cmds.pop_front();
                    s_tdata <= {3'b000, cur.py, cur.px, cur.point, cur.slot};
                    s_tuser <= cur.op;
                    nv = 1'b1;
                    tx_gap = next_pause(tx_run);
                end
            end
            s_tvalid <= nv;
        end
    end

    always @(negedge aclk) begin : drive_out
        int w;
        if (aresetn) begin
            w = rx_wait;
            if (out_done) w = next_pause(rx_run);
            if (w > 0) begin
                m_tready <= 1'b0;
                rx_wait = w - 1;
            end else begin
                m_tready <= 1'b1;
                rx_wait = 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.found = m_tuser[0];
                got.slot = m_tdata[4:0];
                got.off_x = m_tdata[29:5];
                got.off_y = m_tdata[54:30];
                if (picks_due.size() == 0) begin
                    $display("%0t: unexpected result transfer: found=%0b slot=%0d x=%0d y=%0d",
                             $time, got.found, got.slot, $signed(got.off_x),
                             $signed(got.off_y));
                    err_cnt++;
                end else begin
                    want = picks_due.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        err_cnt++;
                    end
                    if (got.slot !== want.slot) begin
                        $display("%0t: target_slot mismatch: expected %0d, actual %0d",
                                 $time, want.slot, got.slot);
                        err_cnt++;
                    end
                    if (got.off_x !== want.off_x) begin
                        $display("%0t: offset_x mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.off_x), $signed(got.off_x));
                        err_cnt++;
                    end
                    if (got.off_y !== want.off_y) begin
                        $display("%0t: offset_y mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.off_y), $signed(got.off_y));
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) take_item(cur);
            in_done <= s_tvalid && s_tready;
            out_done <= m_tvalid && m_tready;
        end
    end

    initial begin
        #5_000_000;
        $display("nearest_target_selector_unit verification failed");
        $finish;
    end

    initial begin : stimulus
        int i;
        int k;
        int m;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        in_done = 1'b0;
        out_done = 1'b0;
        tx_gap = 0;
        rx_wait = 0;
        tx_run = 0;
        rx_run = 0;
        err_cnt = 0;
        n_queued = 0;
        n_loads = 0;
        n_plans = 0;
        n_found = 0;
        n_empty = 0;
        n_ties = 0;
        n_zero = 0;
        for (i = 0; i < NUM_SLOTS; i++) begin
            armed[i] = 1'b0;
            tgt_x[i] = '0;
            tgt_y[i] = '0;
        end

        // empty table, then corners of the coordinate and position ranges
        push_plan(24'sd0, 24'sd0);
        push_plan(24'sd8388607, -24'sd8388608);
        push_load(5'd0, 16'h0000);
        push_load(5'd31, 16'hFFFF);
        push_plan(24'sd8388607, 24'sd8388607);
        push_plan(-24'sd8388608, -24'sd8388608);
        // equal points: lowest slot first, both at zero distance
        push_load(5'd9, 16'h1234);
        push_load(5'd5, 16'h1234);
        push_plan(24'(cm_q8(8'h12)), 24'(cm_q8(8'h34)));
        push_plan(24'(cm_q8(8'h12)), 24'(cm_q8(8'h34)));
        // overwrite a slot that is still pending
        push_load(5'd3, 16'hA55A);
        push_load(5'd3, 16'h5AA5);
        push_plan(-24'sd5000, 24'sd900000);
        push_plan(24'sd0, 24'sd0);
        push_load(5'd16, 16'h00FF);
        push_load(5'd8, 16'hFF00);
        push_load(5'd21, 16'h8080);
        push_plan(24'sd0, 24'(cm_q8(8'hFF)));
        push_plan(24'(cm_q8(8'hFF)), 24'sd0);
        push_plan(24'sd33000, 24'sd33000);
        push_plan(24'sd33000, 24'sd33000);

        // load bursts followed by plans, with some unshaped noise between
        while (n_queued < RUN_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                m = $urandom_range(1, 6);
                for (i = 0; i < m; i++) begin
                    if ($urandom_range(0, 1) == 0) random_load();
                    else push_plan(24'($urandom), 24'($urandom));
                end
            end else begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
                for (i = 0; i < k; i++) random_load();
                m = $urandom_range(1, k + 2);
                for (i = 0; i < m; i++) random_plan();
            end
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid) @(posedge aclk);
        while (picks_due.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (picks_due.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time, picks_due.size());
            err_cnt++;
        end

        $display("Ran %0d target loads and %0d plan requests: %0d picked a target, %0d saw none",
                 n_loads, n_plans, n_found, n_empty);
        $display("Picks decided by slot order on equal distance: %0d, at zero distance: %0d",
                 n_ties, n_zero);
        if (err_cnt == 0) begin
            $display("nearest_target_selector_unit verification clean");
        end else begin
            $display("nearest_target_selector_unit verification failed");
        end
        $finish;
    end

endmodule
